/* rtl/kscd_pkg.sv */
// package with shared constants for the keyboard scan code event decoder
`timescale 1ns / 1ps
`default_nettype none

package kscd_pkg;

    localparam int unsigned NUM_KEYS  = 256;
    localparam int unsigned KEY_W     = $clog2(NUM_KEYS);

    localparam logic [7:0] PREFIX_MATCH = 8'hE1;
    localparam logic [7:0] PREFIX_LSB   = 8'h01;

    localparam logic ACT_SCAN    = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef logic [KEY_W-1:0] t_key;

endpackage

`default_nettype wire

/* rtl/keyboard_scancode_event_decoder.sv */
// top level of the keyboard scan code (set 1) event decoder
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction per clock cycle on the input channel unless it stalls.
// Each accepted transaction sits in an input register, is decoded against the
// last byte, the prefix flag and the 256-bit key table, and its result (if
// any) is loaded from there into the result register that drives o_out_valid.
// While a result waits to be taken, a transaction that makes no result still
// passes through the input register, but one that makes a result holds there
// and stalls the input until the waiting result is taken. The key table is
// flip-flops cleared by reset, so the block is ready as soon as reset is
// released.
module keyboard_scancode_event_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_action,
    input  wire logic [7:0]         i_scan_byte,
    input  wire kscd_pkg::t_key     i_key_index,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_kind,
    output kscd_pkg::t_key          o_key_code,
    output logic                    o_pressed
);
    import kscd_pkg::*;

    logic               r_in_valid;
    logic               r_action;
    logic [7:0]         r_scan_byte;
    t_key               r_key_index;

    logic [7:0]         r_last_byte;
    logic               r_prefix_armed;
    logic [NUM_KEYS-1:0] r_key_down;

    logic               r_out_valid;
    logic               r_kind;
    t_key               r_key_code;
    logic               r_pressed;

    logic               w_is_read;
    logic               w_is_prefix;
    logic               w_is_break;
    logic               w_is_repeat;
    t_key               w_code;
    logic               w_emit;
    logic               w_advance;
    logic               w_out_free;

    logic               n_kind;
    t_key               n_key_code;
    logic               n_pressed;

    always_comb begin
        w_is_read   = (r_action == ACT_READ);
        w_is_prefix = ((r_scan_byte | PREFIX_LSB) == PREFIX_MATCH);
        w_is_break  = r_scan_byte[7];
        w_is_repeat = (r_scan_byte == r_last_byte);
        w_code      = {r_prefix_armed, r_scan_byte[6:0]};
        w_emit      = w_is_read ||
                      (!w_is_prefix && !w_is_repeat && (w_is_break || !r_key_down[w_code]));
        w_out_free  = !r_out_valid || i_out_ready;
        w_advance   = r_in_valid && (w_out_free || !w_emit);
        if (w_is_read) begin
            n_kind     = KIND_STATUS;
            n_key_code = r_key_index;
            n_pressed  = r_key_down[r_key_index];
        end else begin
            n_kind     = KIND_EVENT;
            n_key_code = w_code;
            n_pressed  = !w_is_break;
        end
    end

    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_key_code  = r_key_code;
    assign o_pressed   = r_pressed;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_action    <= i_action;
            r_scan_byte <= i_scan_byte;
            r_key_index <= i_key_index;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_byte    <= '0;
            r_prefix_armed <= 1'b0;
            r_key_down     <= '0;
        end else if (w_advance && !w_is_read) begin
            r_last_byte    <= r_scan_byte;
            r_prefix_armed <= w_is_prefix;
            if (w_emit) begin
                r_key_down[w_code] <= !w_is_break;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_emit;
        end
        if (w_advance && w_emit) begin
            r_kind     <= n_kind;
            r_key_code <= n_key_code;
            r_pressed  <= n_pressed;
        end
    end

    // a waiting result always agrees with the key table
    a_result_matches_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_key_down[r_key_code] == r_pressed))
        else $error("waiting result disagrees with key table");

    // the prefix flag is only armed right after a prefix byte
    a_prefix_follows_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix_armed |-> ((r_last_byte | PREFIX_LSB) == PREFIX_MATCH))
        else $error("prefix armed without prefix byte");

    // decoder state moves only when a transaction leaves the input register
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> ($stable(r_last_byte) && $stable(r_prefix_armed)
                        && $stable(r_key_down)))
        else $error("decoder state changed without a transaction");

    // a status read never changes decoder state
    a_read_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_is_read) |=> ($stable(r_last_byte) && $stable(r_key_down)))
        else $error("status read changed decoder state");

endmodule

`default_nettype wire
